@@ design/crlf_pkg.sv @@
// ============================================================================
// crlf_pkg
// Shared types and constants for the CR LF line receiver.
// ============================================================================
`default_nettype none

package crlf_pkg;

    localparam int unsigned BUFFER_DEPTH_DEF = 256;
    localparam int unsigned QUEUE_DEPTH      = 2;

    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;

    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_DATA,
        CMD_CR,
        CMD_LF,
        CMD_RELEASE,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
        logic       in_range;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

@@ design/crlf_front.sv @@
// ============================================================================
// crlf_front
// Accepts input beats and decodes them into commands for the queue.
// ============================================================================
`default_nettype none

module crlf_front #(
    parameter int unsigned BUFFER_DEPTH = crlf_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [1:0]      s_op,
    input  wire logic [7:0]      s_rx_byte,
    input  wire logic [7:0]      s_read_index,
    input  wire crlf_pkg::q_stat_t q_stat,
    output logic                 push,
    output crlf_pkg::cmd_t       cmd
);

    crlf_pkg::cmd_kind_t kind;

    always_comb begin
        case (s_op)
            crlf_pkg::OP_RX: begin
                if (s_rx_byte == crlf_pkg::CH_CR) begin
                    kind = crlf_pkg::CMD_CR;
                end else if (s_rx_byte == crlf_pkg::CH_LF) begin
                    kind = crlf_pkg::CMD_LF;
                end else begin
                    kind = crlf_pkg::CMD_DATA;
                end
            end
            crlf_pkg::OP_RELEASE: kind = crlf_pkg::CMD_RELEASE;
            crlf_pkg::OP_READ:    kind = crlf_pkg::CMD_READ;
            default:              kind = crlf_pkg::CMD_NOP;
        endcase
    end

    assign s_ready = !q_stat.full;
    assign push    = s_valid && !q_stat.full;

    assign cmd.kind       = kind;
    assign cmd.rx_byte    = s_rx_byte;
    assign cmd.read_index = s_read_index;
    assign cmd.in_range   = ({24'd0, s_read_index} < 32'(BUFFER_DEPTH));

endmodule

`default_nettype wire

@@ design/crlf_queue.sv @@
// ============================================================================
// crlf_queue
// Short command queue between the decode front and the execution back.
// ============================================================================
`default_nettype none

module crlf_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire crlf_pkg::cmd_t    push_cmd,
    input  wire logic              pop,
    output crlf_pkg::cmd_t         pop_cmd,
    output crlf_pkg::q_stat_t      q_stat
);

    localparam int unsigned PTR_W = $clog2(crlf_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(crlf_pkg::QUEUE_DEPTH + 1);

    crlf_pkg::cmd_t    entry_reg [crlf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(crlf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(crlf_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign pop_cmd      = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (cnt_reg == CNT_W'(crlf_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);

endmodule

`default_nettype wire

@@ design/crlf_back.sv @@
// ============================================================================
// crlf_back
// Executes commands: line state, line store and the result register.
// ============================================================================
`default_nettype none

module crlf_back #(
    parameter int unsigned BUFFER_DEPTH = crlf_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire crlf_pkg::cmd_t    cmd,
    input  wire crlf_pkg::q_stat_t q_stat,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_line_done,
    output logic                   m_cr_pending,
    output logic [7:0]             m_line_length,
    output logic [7:0]             m_read_data
);

    localparam int unsigned CNT_W = $clog2(BUFFER_DEPTH);

    logic [7:0]       line_store [BUFFER_DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             cr_reg, cr_next;
    logic             done_reg, done_next;
    logic             out_valid_reg;
    logic             out_done_reg, out_cr_reg;
    logic [7:0]       out_len_reg;
    logic             out_rd_sel_reg;
    logic [7:0]       rd_data_reg;
    logic             store_en;
    logic             issue;
    logic             is_read;

    // Issue when a command waits and the result register is free or draining.
    assign issue   = !q_stat.empty && (!out_valid_reg || m_ready);
    assign pop     = issue;
    assign is_read = (cmd.kind == crlf_pkg::CMD_READ);

    always_comb begin
        count_next = count_reg;
        cr_next    = cr_reg;
        done_next  = done_reg;
        store_en   = 1'b0;
        case (cmd.kind)
            crlf_pkg::CMD_DATA, crlf_pkg::CMD_CR, crlf_pkg::CMD_LF: begin
                if (!done_reg) begin
                    if (cr_reg) begin
                        if (cmd.kind == crlf_pkg::CMD_LF) begin
                            done_next = 1'b1;
                        end else begin
                            // drop the line on anything but LF after CR
                            count_next = '0;
                            cr_next    = 1'b0;
                        end
                    end else if (cmd.kind == crlf_pkg::CMD_CR) begin
                        cr_next = 1'b1;
                    end else begin
                        store_en   = 1'b1;
                        count_next = (count_reg == CNT_W'(BUFFER_DEPTH - 1))
                                   ? '0 : count_reg + 1'b1;
                    end
                end
            end
            crlf_pkg::CMD_RELEASE: begin
                count_next = '0;
                cr_next    = 1'b0;
                done_next  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            cr_reg        <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                count_reg <= count_next;
                cr_reg    <= cr_next;
                done_reg  <= done_next;
            end
            if (issue) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            out_done_reg   <= done_next;
            out_cr_reg     <= cr_next;
            out_len_reg    <= 8'(count_next);
            out_rd_sel_reg <= is_read && cmd.in_range;
        end
    end

    // Line store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (issue && store_en) begin
            line_store[count_reg] <= cmd.rx_byte;
        end
        if (issue && is_read) begin
            rd_data_reg <= line_store[CNT_W'(cmd.read_index)];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_line_done   = out_done_reg;
    assign m_cr_pending  = out_cr_reg;
    assign m_line_length = out_len_reg;
    assign m_read_data   = out_rd_sel_reg ? rd_data_reg : 8'd0;

endmodule

`default_nettype wire

@@ design/crlf_line_receiver.sv @@
// An accepted input beat is written into the command queue; the back end then issues it
// into the result register behind m_valid once that is free or draining. One beat per
// cycle is taken unless the result stalls; the back end issues one command per cycle
// from a two-entry queue, and the line store takes one write and one read per cycle.
// Reset (aresetn low, synchronous) clears the count, both flags and the queue;
// the line store is not cleared and holds undefined data until written.
// ============================================================================
// crlf_line_receiver
// Receive buffer that assembles one CR LF terminated line from serial bytes.
// ============================================================================
`default_nettype none

module crlf_line_receiver #(
    parameter int unsigned BUFFER_DEPTH = crlf_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_op,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic [7:0] s_read_index,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_line_done,
    output logic            m_cr_pending,
    output logic [7:0]      m_line_length,
    output logic [7:0]      m_read_data
);

    crlf_pkg::cmd_t    push_cmd;
    crlf_pkg::cmd_t    pop_cmd;
    crlf_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;

    crlf_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_rx_byte    (s_rx_byte),
        .s_read_index (s_read_index),
        .q_stat       (q_stat),
        .push         (push),
        .cmd          (push_cmd)
    );

    crlf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    crlf_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (pop_cmd),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_done   (m_line_done),
        .m_cr_pending  (m_cr_pending),
        .m_line_length (m_line_length),
        .m_read_data   (m_read_data)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("push into full command queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty command queue");

    a_done_has_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_done) |-> m_cr_pending)
        else $error("line done reported without CR flag");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_line_length)
                                   && $stable(m_read_data)))
        else $error("result beat changed while stalled");
`endif

endmodule

`default_nettype wire
